FILE: src/mep_pkg.sv
package mep_pkg;

    localparam int PIXEL_COLUMNS = 8192;
    localparam int PIXEL_ROWS    = 8192;

    localparam int Q_W     = 32;
    localparam int STEP_W  = 31;
    localparam int CNT_W   = 16;
    localparam int IDX_W   = 13;
    localparam int DIV_STEPS = 16;

    localparam logic signed [31:0] REAL_ORIGIN_RST = -32'sd671088640;
    localparam logic [30:0]        REAL_STEP_RST   = 31'd122350;
    localparam logic signed [31:0] IMAG_ORIGIN_RST = -32'sd335544320;
    localparam logic [30:0]        IMAG_STEP_RST   = 31'd155381;
    localparam logic [15:0]        LIMIT_RST       = 16'd1000;

    localparam logic [63:0] FOUR_Q56 = 64'h0400_0000_0000_0000;

    localparam logic [16:0] K_RED   = 17'd2295;
    localparam logic [16:0] K_GREEN = 17'd3825;
    localparam logic [16:0] K_BLUE  = 17'd4335;

    typedef enum logic [2:0] {
        REG_REAL_ORIGIN = 3'd0,
        REG_REAL_STEP   = 3'd1,
        REG_IMAG_ORIGIN = 3'd2,
        REG_IMAG_STEP   = 3'd3,
        REG_LIMIT       = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic        valid;
        logic [15:0] rem;
        logic [15:0] quo;
    } div_stage_t;

    function automatic logic signed [31:0] sat_q(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (v < -64'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

FILE: src/mep_div_cell.sv
module mep_div_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [15:0]         divisor,
    input  mep_pkg::div_stage_t din,
    output mep_pkg::div_stage_t dout
);

    logic [16:0] shifted;
    logic [16:0] diff;
    logic        ge;

    assign shifted = {din.rem, 1'b0};
    assign ge      = shifted >= {1'b0, divisor};
    assign diff    = shifted - {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dout <= '0;
        end
        else
        begin
            dout.valid <= din.valid;
            dout.rem   <= ge ? diff[15:0] : shifted[15:0];
            dout.quo   <= {din.quo[14:0], ge};
        end
    end

endmodule

FILE: src/mep_color.sv
module mep_color (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] count,
    input  logic [15:0] limit,
    output logic        done,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue
);

    typedef enum logic [1:0] {M_IDLE, M_LOAD, M_RUN} mstate_t;

    mep_pkg::div_stage_t stage [mep_pkg::DIV_STEPS+1];

    assign stage[0] = '{valid: start, rem: count, quo: 16'd0};

    for (genvar g = 0; g < mep_pkg::DIV_STEPS; g++)
    begin : g_div
        mep_div_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .divisor (limit),
            .din     (stage[g]),
            .dout    (stage[g+1])
        );
    end

    mstate_t     state_reg;
    logic [15:0] t_reg;
    logic [16:0] u_reg;
    logic [79:0] p_reg;
    logic [79:0] mcand_reg;
    logic [16:0] mplier_reg;
    logic [79:0] acc_reg;
    logic [4:0]  bit_reg;
    logic [2:0]  fac_reg;
    logic [1:0]  col_reg;
    logic        done_reg;
    logic [7:0]  red_reg;
    logic [7:0]  green_reg;
    logic [7:0]  blue_reg;

    logic [16:0] factor;
    logic [79:0] acc_next;

    always_comb
    begin
        if (fac_reg == 3'd4)
        begin
            unique case (col_reg)
                2'd0:    factor = mep_pkg::K_RED;
                2'd1:    factor = mep_pkg::K_GREEN;
                default: factor = mep_pkg::K_BLUE;
            endcase
        end
        else if (fac_reg < ({1'b0, col_reg} + 3'd1))
            factor = u_reg;
        else
            factor = {1'b0, t_reg};
    end

    assign acc_next = acc_reg + (mplier_reg[0] ? mcand_reg : 80'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= M_IDLE;
            done_reg   <= 1'b0;
            t_reg      <= '0;
            u_reg      <= '0;
            p_reg      <= '0;
            mcand_reg  <= '0;
            mplier_reg <= '0;
            acc_reg    <= '0;
            bit_reg    <= '0;
            fac_reg    <= '0;
            col_reg    <= '0;
            red_reg    <= '0;
            green_reg  <= '0;
            blue_reg   <= '0;
        end
        else
        begin
            done_reg <= (state_reg == M_RUN) && (bit_reg == 5'd16) && (fac_reg == 3'd4)
                        && (col_reg == 2'd2);
            unique case (state_reg)
                M_IDLE:
                begin
                    if (stage[mep_pkg::DIV_STEPS].valid)
                    begin
                        t_reg     <= stage[mep_pkg::DIV_STEPS].quo;
                        u_reg     <= 17'h10000 - {1'b0, stage[mep_pkg::DIV_STEPS].quo};
                        p_reg     <= 80'd1;
                        fac_reg   <= 3'd0;
                        col_reg   <= 2'd0;
                        state_reg <= M_LOAD;
                    end
                end
                M_LOAD:
                begin
                    mcand_reg  <= p_reg;
                    mplier_reg <= factor;
                    acc_reg    <= '0;
                    bit_reg    <= '0;
                    state_reg  <= M_RUN;
                end
                M_RUN:
                begin
                    acc_reg    <= acc_next;
                    mcand_reg  <= {mcand_reg[78:0], 1'b0};
                    mplier_reg <= {1'b0, mplier_reg[16:1]};
                    bit_reg    <= bit_reg + 5'd1;
                    if (bit_reg == 5'd16)
                    begin
                        if (fac_reg == 3'd4)
                        begin
                            p_reg   <= 80'd1;
                            fac_reg <= 3'd0;
                            unique case (col_reg)
                                2'd0:    red_reg   <= acc_next[71:64];
                                2'd1:    green_reg <= acc_next[71:64];
                                default: blue_reg  <= acc_next[72:65];
                            endcase
                            if (col_reg == 2'd2)
                                state_reg <= M_IDLE;
                            else
                            begin
                                col_reg   <= col_reg + 2'd1;
                                state_reg <= M_LOAD;
                            end
                        end
                        else
                        begin
                            p_reg     <= acc_next;
                            fac_reg   <= fac_reg + 3'd1;
                            state_reg <= M_LOAD;
                        end
                    end
                end
                default:
                    state_reg <= M_IDLE;
            endcase
        end
    end

    assign done  = done_reg;
    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

endmodule

FILE: src/mandelbrot_escape_pixel.sv
// The z*z+c loop runs one iteration per cycle; a point that reaches the limit skips the color step.
// Color: a 16-cell divider chain for t, then a shift-add multiplier.
// One item in flight; in_stall falls in the same cycle as the result is posted to out_valid.
// rst_n (async, active low) clears control state and loads the register defaults.
module mandelbrot_escape_pixel #(
    parameter int PIXEL_COLUMNS = mep_pkg::PIXEL_COLUMNS,
    parameter int PIXEL_ROWS    = mep_pkg::PIXEL_ROWS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [12:0] column,
    input  logic [12:0] row,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] iterations,
    output logic        inside_res,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue
);

    localparam logic [16:0] COL_MAX = 17'(PIXEL_COLUMNS - 1);
    localparam logic [16:0] ROW_MAX = 17'(PIXEL_ROWS - 1);

    typedef enum logic [1:0] {S_IDLE, S_ITER, S_COLOR, S_DONE} state_t;

    logic signed [31:0] real_origin_reg;
    logic [30:0]        real_step_reg;
    logic signed [31:0] imag_origin_reg;
    logic [30:0]        imag_step_reg;
    logic [15:0]        limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            real_origin_reg <= mep_pkg::REAL_ORIGIN_RST;
            real_step_reg   <= mep_pkg::REAL_STEP_RST;
            imag_origin_reg <= mep_pkg::IMAG_ORIGIN_RST;
            imag_step_reg   <= mep_pkg::IMAG_STEP_RST;
            limit_reg       <= mep_pkg::LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mep_pkg::REG_REAL_ORIGIN: real_origin_reg <= cfg_data;
                mep_pkg::REG_REAL_STEP:   real_step_reg   <= cfg_data[30:0];
                mep_pkg::REG_IMAG_ORIGIN: imag_origin_reg <= cfg_data;
                mep_pkg::REG_IMAG_STEP:   imag_step_reg   <= cfg_data[30:0];
                mep_pkg::REG_LIMIT:       limit_reg       <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // coordinate mapping
    logic [12:0]        col_c;
    logic [12:0]        row_c;
    logic [43:0]        cx_off;
    logic [43:0]        cy_off;
    logic signed [31:0] cx_new;
    logic signed [31:0] cy_new;

    assign col_c  = ({4'd0, column} > COL_MAX) ? COL_MAX[12:0] : column;
    assign row_c  = ({4'd0, row} > ROW_MAX) ? ROW_MAX[12:0] : row;
    assign cx_off = real_step_reg * col_c;
    assign cy_off = imag_step_reg * row_c;
    assign cx_new = mep_pkg::sat_q(64'(real_origin_reg) + $signed({20'd0, cx_off}));
    assign cy_new = mep_pkg::sat_q(64'(imag_origin_reg) + $signed({20'd0, cy_off}));

    // iteration datapath
    state_t             state_reg;
    logic signed [31:0] cx_reg;
    logic signed [31:0] cy_reg;
    logic signed [31:0] zx_reg;
    logic signed [31:0] zy_reg;
    logic [15:0]        count_reg;
    logic               start_reg;
    logic               inside_reg;
    logic [7:0]         red_reg;
    logic [7:0]         green_reg;
    logic [7:0]         blue_reg;
    logic               out_valid_reg;
    logic [15:0]        iter_out_reg;
    logic               inside_out_reg;
    logic [7:0]         red_out_reg;
    logic [7:0]         green_out_reg;
    logic [7:0]         blue_out_reg;

    logic signed [63:0] sx;
    logic signed [63:0] sy;
    logic signed [63:0] pxy;
    logic [63:0]        mag;
    logic signed [63:0] diff;
    logic               escape;
    logic signed [31:0] zx_new;
    logic signed [31:0] zy_new;

    assign sx     = zx_reg * zx_reg;
    assign sy     = zy_reg * zy_reg;
    assign pxy    = zx_reg * zy_reg;
    assign mag    = sx + sy;
    assign escape = mag > mep_pkg::FOUR_Q56;
    assign diff   = sx - sy;
    assign zx_new = mep_pkg::sat_q((diff >>> 28) + 64'(cx_reg));
    assign zy_new = mep_pkg::sat_q((pxy >>> 27) + 64'(cy_reg));

    logic       col_done;
    logic [7:0] col_red;
    logic [7:0] col_green;
    logic [7:0] col_blue;

    mep_color u_color (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_reg),
        .count (count_reg),
        .limit (limit_reg),
        .done  (col_done),
        .red   (col_red),
        .green (col_green),
        .blue  (col_blue)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cx_reg         <= '0;
            cy_reg         <= '0;
            zx_reg         <= '0;
            zy_reg         <= '0;
            count_reg      <= '0;
            start_reg      <= 1'b0;
            inside_reg     <= 1'b0;
            red_reg        <= '0;
            green_reg      <= '0;
            blue_reg       <= '0;
            out_valid_reg  <= 1'b0;
            iter_out_reg   <= '0;
            inside_out_reg <= 1'b0;
            red_out_reg    <= '0;
            green_out_reg  <= '0;
            blue_out_reg   <= '0;
        end
        else
        begin
            start_reg <= (state_reg == S_ITER) && (count_reg != limit_reg) && escape;
            if ((state_reg == S_DONE) && (!out_valid_reg || !out_stall))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        cx_reg    <= cx_new;
                        cy_reg    <= cy_new;
                        zx_reg    <= '0;
                        zy_reg    <= '0;
                        count_reg <= '0;
                        state_reg <= S_ITER;
                    end
                end
                S_ITER:
                begin
                    if (count_reg == limit_reg)
                    begin
                        inside_reg <= 1'b1;
                        red_reg    <= '0;
                        green_reg  <= '0;
                        blue_reg   <= '0;
                        state_reg  <= S_DONE;
                    end
                    else if (escape)
                    begin
                        inside_reg <= 1'b0;
                        state_reg  <= S_COLOR;
                    end
                    else
                    begin
                        zx_reg    <= zx_new;
                        zy_reg    <= zy_new;
                        count_reg <= count_reg + 16'd1;
                    end
                end
                S_COLOR:
                begin
                    if (col_done)
                    begin
                        red_reg   <= col_red;
                        green_reg <= col_green;
                        blue_reg  <= col_blue;
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        iter_out_reg   <= count_reg;
                        inside_out_reg <= inside_reg;
                        red_out_reg    <= red_reg;
                        green_out_reg  <= green_reg;
                        blue_out_reg   <= blue_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign iterations = iter_out_reg;
    assign inside_res = inside_out_reg;
    assign red        = red_out_reg;
    assign green      = green_out_reg;
    assign blue       = blue_out_reg;

endmodule

FILE: test/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [15:0] iter;
        logic        in_set;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
    } pixel_t;

    typedef struct {
        logic     is_cfg;
        mep_pkg::cfg_reg_t ridx;
        logic [31:0] data;
        logic [12:0] col;
        logic [12:0] row;
        logic     fixed;
        pixel_t   res;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [12:0] column;
    logic [12:0] row;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] iterations;
    logic        inside_res;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;

    mandelbrot_escape_pixel dut (.*);

    logic signed [31:0] re_org;
    logic [30:0]        re_step;
    logic signed [31:0] im_org;
    logic [30:0]        im_step;
    logic [15:0]        iter_lim;

    pixel_t    pending_pixels[$];
    stim_row_t stim_rows[$];
    int        err_cnt;
    int        send_idle;
    int        recv_idle;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #400ms;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic longint clip_q(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic [63:0] scale_hi(logic [63:0] p, logic [15:0] k);
        logic [127:0] w;
        w = {64'd0, p} * {112'd0, k};
        return w[127:64];
    endfunction

    function automatic pixel_t escape_pixel(logic [12:0] c, logic [12:0] r);
        longint      cx, cy, zx, zy, diff, prod;
        logic [63:0] sx, sy, t, u;
        int unsigned n;
        int unsigned cc, rr;
        pixel_t      p;
        cc = (c > mep_pkg::PIXEL_COLUMNS - 1) ? mep_pkg::PIXEL_COLUMNS - 1 : c;
        rr = (r > mep_pkg::PIXEL_ROWS - 1) ? mep_pkg::PIXEL_ROWS - 1 : r;
        cx = clip_q(longint'(re_org) + longint'(re_step) * longint'(cc));
        cy = clip_q(longint'(im_org) + longint'(im_step) * longint'(rr));
        zx = 0;
        zy = 0;
        n = 0;
        while (n < iter_lim)
        begin
            sx = 64'(zx * zx);
            sy = 64'(zy * zy);
            if (sx + sy > mep_pkg::FOUR_Q56)
                break;
            diff = longint'(sx) - longint'(sy);
            prod = zx * zy;
            zx = clip_q((diff >>> 28) + cx);
            zy = clip_q((prod >>> 27) + cy);
            n++;
        end
        p.iter = n[15:0];
        p.in_set = (n == iter_lim);
        p.r = '0;
        p.g = '0;
        p.b = '0;
        if (!p.in_set)
        begin
            t = (64'(n) << 16) / 64'(iter_lim);
            u = 64'd65536 - t;
            p.r = 8'(scale_hi(u * t * t * t, 16'd2295));
            p.g = 8'(scale_hi(u * u * t * t, 16'd3825));
            p.b = 8'(scale_hi(u * u * u * t, 16'd4335) >> 1);
        end
        return p;
    endfunction

    task automatic write_reg(mep_pkg::cfg_reg_t idx, logic [31:0] d);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        case (idx)
            mep_pkg::REG_REAL_ORIGIN: re_org = d;
            mep_pkg::REG_REAL_STEP:   re_step = d[30:0];
            mep_pkg::REG_IMAG_ORIGIN: im_org = d;
            mep_pkg::REG_IMAG_STEP:   im_step = d[30:0];
            mep_pkg::REG_LIMIT:       iter_lim = d[15:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_pixel(logic [12:0] c, logic [12:0] r, logic fixed, pixel_t res);
        @(negedge clk);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        column <= c;
        row <= r;
        do
            @(posedge clk);
        while (in_stall);
        pending_pixels.push_back(fixed ? res : escape_pixel(c, r));
    endtask

    task automatic add_cfg(mep_pkg::cfg_reg_t idx, logic [31:0] d);
        stim_row_t s;
        s = '{1'b1, idx, d, 13'd0, 13'd0, 1'b0, '{0, 0, 0, 0, 0}};
        stim_rows.push_back(s);
    endtask

    task automatic add_pix(logic [12:0] c, logic [12:0] r, logic fixed, pixel_t res);
        stim_row_t s;
        s = '{1'b0, mep_pkg::REG_LIMIT, 32'd0, c, r, fixed, res};
        stim_rows.push_back(s);
    endtask

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_idle);

    always @(posedge clk)
    begin
        pixel_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_pixels.size() == 0)
            begin
                $error("unexpected item: iterations %0d", iterations);
                err_cnt++;
            end
            else
            begin
                e = pending_pixels.pop_front();
                if (iterations !== e.iter)
                begin
                    $error("iterations exp %0d got %0d", e.iter, iterations);
                    err_cnt++;
                end
                if (inside_res !== e.in_set)
                begin
                    $error("inside_res exp %0d got %0d", e.in_set, inside_res);
                    err_cnt++;
                end
                if (red !== e.r)
                begin
                    $error("red exp %0d got %0d", e.r, red);
                    err_cnt++;
                end
                if (green !== e.g)
                begin
                    $error("green exp %0d got %0d", e.g, green);
                    err_cnt++;
                end
                if (blue !== e.b)
                begin
                    $error("blue exp %0d got %0d", e.b, blue);
                    err_cnt++;
                end
            end
        end
    end

    initial
    begin
        pixel_t      none, in_lim1, in_lim0;
        stim_row_t   s;
        logic [31:0] d;
        int          waited;

        none = '{0, 0, 0, 0, 0};
        in_lim1 = '{16'd1, 1'b1, 8'd0, 8'd0, 8'd0};
        in_lim0 = '{16'd0, 1'b1, 8'd0, 8'd0, 8'd0};
        err_cnt = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        column = '0;
        row = '0;
        out_stall = 1'b0;
        send_idle = 36;
        recv_idle = 82;
        re_org = mep_pkg::REAL_ORIGIN_RST;
        re_step = mep_pkg::REAL_STEP_RST;
        im_org = mep_pkg::IMAG_ORIGIN_RST;
        im_step = mep_pkg::IMAG_STEP_RST;
        iter_lim = mep_pkg::LIMIT_RST;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        add_pix(13'd0, 13'd0, 1'b0, none);
        add_pix(13'd8191, 13'd8191, 1'b0, none);
        add_pix(13'd4096, 13'd2048, 1'b0, none);
        add_pix(13'h1555, 13'h0AAA, 1'b0, none);
        add_pix(13'd2600, 13'd4096, 1'b0, none);
        add_cfg(mep_pkg::REG_LIMIT, 32'd1);
        add_pix(13'd123, 13'd456, 1'b1, in_lim1);
        add_pix(13'd8191, 13'd0, 1'b1, in_lim1);
        add_cfg(mep_pkg::REG_LIMIT, 32'd0);
        add_pix(13'd8191, 13'd0, 1'b1, in_lim0);
        add_pix(13'd0, 13'd8191, 1'b1, in_lim0);
        add_cfg(mep_pkg::REG_LIMIT, 32'd65535);
        add_cfg(mep_pkg::REG_REAL_ORIGIN, 32'h7FFF_FFFF);
        add_cfg(mep_pkg::REG_REAL_STEP, 32'h7FFF_FFFF);
        add_cfg(mep_pkg::REG_IMAG_ORIGIN, 32'h8000_0000);
        add_cfg(mep_pkg::REG_IMAG_STEP, 32'h7FFF_FFFF);
        add_pix(13'd0, 13'd0, 1'b0, none);
        add_pix(13'd8191, 13'd8191, 1'b0, none);
        add_cfg(mep_pkg::REG_REAL_ORIGIN, 32'h8000_0000);
        add_cfg(mep_pkg::REG_IMAG_ORIGIN, 32'h7FFF_FFFF);
        add_pix(13'd1, 13'd1, 1'b0, none);
        add_cfg(mep_pkg::REG_REAL_ORIGIN, 32'd0);
        add_cfg(mep_pkg::REG_REAL_STEP, 32'd0);
        add_cfg(mep_pkg::REG_IMAG_ORIGIN, 32'd0);
        add_cfg(mep_pkg::REG_IMAG_STEP, 32'd0);
        add_pix(13'd17, 13'd9, 1'b0, none);
        add_cfg(mep_pkg::REG_LIMIT, 32'd300);
        add_cfg(mep_pkg::REG_REAL_ORIGIN, 32'hF000_0000);
        add_pix(13'd5, 13'd5, 1'b0, none);

        foreach (stim_rows[i])
        begin
            s = stim_rows[i];
            if (s.is_cfg)
            begin
                wait_drained();
                write_reg(s.ridx, s.data);
            end
            else
                send_pixel(s.col, s.row, s.fixed, s.res);
        end

        for (int ph = 0; ph < 6; ph++)
        begin
            wait_drained();
            send_idle = (ph < 2) ? 36 : (ph < 4) ? 82 : 0;
            recv_idle = (ph < 2) ? 82 : (ph < 4) ? 36 : 0;
            if (ph == 3)
            begin
                write_reg(mep_pkg::REG_REAL_ORIGIN, $urandom);
                write_reg(mep_pkg::REG_REAL_STEP, $urandom);
                write_reg(mep_pkg::REG_IMAG_ORIGIN, $urandom);
                write_reg(mep_pkg::REG_IMAG_STEP, $urandom);
                write_reg(mep_pkg::REG_LIMIT, $urandom_range(1, 65535));
            end
            else
            begin
                d = $urandom_range(32'd939524096) - 32'd671088640;
                write_reg(mep_pkg::REG_REAL_ORIGIN, d);
                write_reg(mep_pkg::REG_REAL_STEP, $urandom_range(400000));
                d = $urandom_range(32'd671088640) - 32'd335544320;
                write_reg(mep_pkg::REG_IMAG_ORIGIN, d);
                write_reg(mep_pkg::REG_IMAG_STEP, $urandom_range(400000));
                write_reg(mep_pkg::REG_LIMIT, $urandom_range(2, 250));
            end
            for (int k = 0; k < 100; k++)
            begin
                if (k == 50 && ph == 1)
                begin
                    wait_drained();
                    write_reg(mep_pkg::REG_LIMIT, $urandom_range(2, 250));
                end
                if ($urandom_range(3) == 0)
                    send_pixel(13'($urandom), 13'($urandom), 1'b0, none);
                else
                    send_pixel(13'($urandom_range(2047)), 13'($urandom_range(2047)), 1'b0,
                               none);
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        waited = 0;
        while (pending_pixels.size() != 0 && waited < 200000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (400) @(posedge clk);
        if (pending_pixels.size() != 0)
        begin
            $error("%0d expected items never arrived", pending_pixels.size());
            err_cnt++;
        end
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
